/* hdl/baro_pressure_temp_compensation_core_assert.svh */
// Assertion macros used by the compensation core checker
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication
`define BPTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bptc_pkg.sv */
// Types, constants and helpers for the barometric compensation core
package bptc_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK  = 2'd0;
    localparam status_t STATUS_DIV = 2'd1;
    localparam status_t STATUS_SAT = 2'd2;

    localparam logic [2:0] REG_OSS    = 3'd0;
    localparam logic [2:0] REG_AC123  = 3'd1;
    localparam logic [2:0] REG_AC456  = 3'd2;
    localparam logic [2:0] REG_B12    = 3'd3;
    localparam logic [2:0] REG_MCMD   = 3'd4;

    localparam int CFG_W    = 48;
    localparam int DIVA_W   = 27;  // |mc << 11| fits 27 bits
    localparam int DIVB_W   = 32;

    localparam logic [31:0] K_B6_OFS   = 32'd4000;
    localparam logic [31:0] K_HALF     = 32'd32768;
    localparam logic [31:0] K_SCALE    = 32'd50000;
    localparam logic [31:0] K_C3038    = 32'd3038;
    localparam logic [31:0] K_C7357    = 32'd7357;
    localparam logic [31:0] K_C3791    = 32'd3791;
    localparam logic [31:0] K_T_MAX    = 32'd32767;
    localparam logic [31:0] K_P_MAX    = 32'd262143;

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
        logic signed [31:0] sv;
        sv = $signed(v);
        return 32'(sv >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* hdl/baro_pressure_temp_compensation_core.sv */
// Barometric pressure and temperature compensation core, fully pipelined
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_raw_temperature       | in
//          | s_raw_pressure_word                     |
//  result  | m_valid m_ready m_temperature_tenths    | out
//          | m_pressure_pa m_status                  |
//  config  | cfg_we cfg_index cfg_wdata              | in
//
// One request per cycle while no result is held; the two bit-per-stage dividers
// take 27 stages for the temperature divide and 32 for the pressure divide.
// aresetn is synchronous; it clears valid bits and calibration registers.
// A held result freezes the whole pipeline; nothing is dropped or repeated.
module baro_pressure_temp_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_raw_temperature,
    input  logic [23:0] s_raw_pressure_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_temperature_tenths,
    output logic [17:0] m_pressure_pa,
    output logic [1:0]  m_status,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);

    localparam int AW = bptc_pkg::DIVA_W;
    localparam int BW = bptc_pkg::DIVB_W;

    // configuration
    logic [1:0]  oss_reg;
    logic [47:0] ac123_reg, ac456_reg;
    logic [31:0] b12_reg, mcmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oss_reg   <= '0;
            ac123_reg <= '0;
            ac456_reg <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                bptc_pkg::REG_OSS:   oss_reg   <= cfg_wdata[1:0];
                bptc_pkg::REG_AC123: ac123_reg <= cfg_wdata;
                bptc_pkg::REG_AC456: ac456_reg <= cfg_wdata;
                bptc_pkg::REG_B12:   b12_reg   <= cfg_wdata[31:0];
                bptc_pkg::REG_MCMD:  mcmd_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = bptc_pkg::sx16(ac123_reg[47:32]);
    assign ac2 = bptc_pkg::sx16(ac123_reg[31:16]);
    assign ac3 = bptc_pkg::sx16(ac123_reg[15:0]);
    assign ac4 = {16'd0, ac456_reg[47:32]};
    assign ac5 = {16'd0, ac456_reg[31:16]};
    assign ac6 = {16'd0, ac456_reg[15:0]};
    assign b1  = bptc_pkg::sx16(b12_reg[31:16]);
    assign b2  = bptc_pkg::sx16(b12_reg[15:0]);
    assign mc  = bptc_pkg::sx16(mcmd_reg[31:16]);
    assign md  = bptc_pkg::sx16(mcmd_reg[15:0]);

    // global pipeline advance
    logic adv;
    logic out_vld_reg;
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    // stage 1: ut - ac6, up
    logic               v1_reg;
    logic signed [16:0] d1_reg;
    logic [23:0]        up1_reg;
    // stage 2: x1
    logic               v2_reg;
    logic [31:0]        x1_2_reg;
    logic [23:0]        up2_reg;
    // stage 3: temperature divisor
    logic               v3_reg;
    logic [31:0]        den3_reg, x1_3_reg;
    logic [23:0]        up3_reg;

    logic signed [33:0] p2_next;
    assign p2_next = d1_reg * $signed({1'b0, ac5[15:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg   <= $signed({1'b0, s_raw_temperature}) - $signed({1'b0, ac6[15:0]});
            up1_reg  <= s_raw_pressure_word >> (4'd8 - {2'b00, oss_reg});
            x1_2_reg <= bptc_pkg::asr(p2_next[31:0], 15);
            up2_reg  <= up1_reg;
            den3_reg <= x1_2_reg + md;
            x1_3_reg <= x1_2_reg;
            up3_reg  <= up2_reg;
        end
    end

    // divider A: |mc<<11| / |den|
    logic          a_vld_reg [AW+1];
    logic [AW-1:0] a_r_reg   [AW+1];
    logic [AW-1:0] a_nq_reg  [AW+1];
    logic [31:0]   a_d_reg   [AW+1];
    logic          a_neg_reg [AW+1];
    logic          a_dz_reg  [AW+1];
    logic [31:0]   a_x1_reg  [AW+1];
    logic [23:0]   a_up_reg  [AW+1];

    logic [31:0] num_a, nmag_a, dmag_a;
    assign num_a  = mc << 11;
    assign nmag_a = mc[31] ? (32'd0 - num_a) : num_a;
    assign dmag_a = den3_reg[31] ? (32'd0 - den3_reg) : den3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= AW; i++) a_vld_reg[i] <= 1'b0;
        end else if (adv) begin
            a_vld_reg[0] <= v3_reg;
            for (int i = 0; i < AW; i++) a_vld_reg[i+1] <= a_vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        logic [AW:0] rn;
        logic [AW:0] rs;
        logic        ge;
        if (adv) begin
            a_r_reg[0]   <= '0;
            a_nq_reg[0]  <= nmag_a[AW-1:0];
            a_d_reg[0]   <= dmag_a;
            a_neg_reg[0] <= mc[31] ^ den3_reg[31];
            a_dz_reg[0]  <= (den3_reg == 32'd0);
            a_x1_reg[0]  <= x1_3_reg;
            a_up_reg[0]  <= up3_reg;
            for (int i = 0; i < AW; i++) begin
                rn = {a_r_reg[i], a_nq_reg[i][AW-1]};
                ge = ({{(32-AW-1){1'b0}}, rn} >= a_d_reg[i]);
                rs = rn - a_d_reg[i][AW:0];
                a_r_reg[i+1]   <= ge ? rs[AW-1:0] : rn[AW-1:0];
                a_nq_reg[i+1]  <= {a_nq_reg[i][AW-2:0], ge};
                a_d_reg[i+1]   <= a_d_reg[i];
                a_neg_reg[i+1] <= a_neg_reg[i];
                a_dz_reg[i+1]  <= a_dz_reg[i];
                a_x1_reg[i+1]  <= a_x1_reg[i];
                a_up_reg[i+1]  <= a_up_reg[i];
            end
        end
    end

    // T stages: b5 .. b7
    localparam int TN = 9;
    logic        tv_reg [TN];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TN; i++) tv_reg[i] <= 1'b0;
        end else if (adv) begin
            tv_reg[0] <= a_vld_reg[AW];
            for (int i = 1; i < TN; i++) tv_reg[i] <= tv_reg[i-1];
        end
    end

    logic [31:0] t1_x2_reg, t1_x1_reg;
    logic [31:0] t2_b5_reg;
    logic [31:0] t3_t_reg, t3_b6_reg;
    logic [31:0] t4_sq_reg, t4_mac2_reg, t4_mac3_reg, t4_t_reg;
    logic [31:0] t5_pb2_reg, t5_pb1_reg, t5_x2a_reg, t5_x1b_reg, t5_t_reg;
    logic [31:0] t6_x3a_reg, t6_x3bp_reg, t6_t_reg;
    logic [31:0] t7_b3p_reg, t7_x3c_reg, t7_t_reg;
    logic [31:0] t8_b3_reg, t8_b4_reg, t8_t_reg;
    logic [31:0] t9_b7p_reg, t9_b4_reg, t9_t_reg;
    logic        t9_bz_reg;
    logic [23:0] t1_up_reg, t2_up_reg, t3_up_reg, t4_up_reg, t5_up_reg, t6_up_reg;
    logic [23:0] t7_up_reg, t8_up_reg;
    logic        tdz_reg [TN];

    logic [31:0] q_a, s12, b4_prod, b3_sh, b7_next, b7_n;
    assign q_a     = {{(32-AW){1'b0}}, a_nq_reg[AW]};
    assign s12     = bptc_pkg::asr(t4_sq_reg, 12);
    assign b4_prod = ac4 * t7_x3c_reg;
    assign b3_sh   = (t7_b3p_reg << oss_reg) + 32'd2;
    assign b7_next = t9_b7p_reg * (bptc_pkg::K_SCALE >> oss_reg);
    assign b7_n    = b7_next[31] ? b7_next : {b7_next[30:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_x2_reg   <= a_neg_reg[AW] ? (32'd0 - q_a) : q_a;
            t1_x1_reg   <= a_x1_reg[AW];
            t1_up_reg   <= a_up_reg[AW];
            tdz_reg[0]  <= a_dz_reg[AW];
            for (int i = 1; i < TN; i++) tdz_reg[i] <= tdz_reg[i-1];

            t2_b5_reg   <= t1_x1_reg + t1_x2_reg;
            t2_up_reg   <= t1_up_reg;

            t3_t_reg    <= bptc_pkg::asr(t2_b5_reg + 32'd8, 4);
            t3_b6_reg   <= t2_b5_reg - bptc_pkg::K_B6_OFS;
            t3_up_reg   <= t2_up_reg;

            t4_sq_reg   <= t3_b6_reg * t3_b6_reg;
            t4_mac2_reg <= ac2 * t3_b6_reg;
            t4_mac3_reg <= ac3 * t3_b6_reg;
            t4_t_reg    <= t3_t_reg;
            t4_up_reg   <= t3_up_reg;

            t5_pb2_reg  <= b2 * s12;
            t5_pb1_reg  <= b1 * s12;
            t5_x2a_reg  <= bptc_pkg::asr(t4_mac2_reg, 11);
            t5_x1b_reg  <= bptc_pkg::asr(t4_mac3_reg, 13);
            t5_t_reg    <= t4_t_reg;
            t5_up_reg   <= t4_up_reg;

            t6_x3a_reg  <= bptc_pkg::asr(t5_pb2_reg, 11) + t5_x2a_reg;
            t6_x3bp_reg <= t5_x1b_reg + bptc_pkg::asr(t5_pb1_reg, 16) + 32'd2;
            t6_t_reg    <= t5_t_reg;
            t6_up_reg   <= t5_up_reg;

            t7_b3p_reg  <= (ac1 << 2) + t6_x3a_reg;
            t7_x3c_reg  <= bptc_pkg::asr(t6_x3bp_reg, 2) + bptc_pkg::K_HALF;
            t7_t_reg    <= t6_t_reg;
            t7_up_reg   <= t6_up_reg;

            t8_b3_reg   <= bptc_pkg::asr(b3_sh, 2);
            t8_b4_reg   <= b4_prod >> 15;
            t8_t_reg    <= t7_t_reg;
            t8_up_reg   <= t7_up_reg;

            t9_b7p_reg  <= {8'd0, t8_up_reg} - t8_b3_reg;
            t9_b4_reg   <= t8_b4_reg;
            t9_bz_reg   <= (t8_b4_reg == 32'd0);
            t9_t_reg    <= t8_t_reg;
        end
    end

    // divider B: unsigned b7 path
    logic          b_vld_reg  [BW+1];
    logic [BW-1:0] b_r_reg    [BW+1];
    logic [BW-1:0] b_nq_reg   [BW+1];
    logic [31:0]   b_d_reg    [BW+1];
    logic          b_post_reg [BW+1];
    logic          b_dz_reg   [BW+1];
    logic          b_bz_reg   [BW+1];
    logic [31:0]   b_t_reg    [BW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= BW; i++) b_vld_reg[i] <= 1'b0;
        end else if (adv) begin
            b_vld_reg[0] <= tv_reg[TN-1];
            for (int i = 0; i < BW; i++) b_vld_reg[i+1] <= b_vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        logic [BW:0] rn;
        logic [BW:0] rs;
        logic        ge;
        if (adv) begin
            b_r_reg[0]    <= '0;
            b_nq_reg[0]   <= b7_n;
            b_d_reg[0]    <= t9_b4_reg;
            b_post_reg[0] <= b7_next[31];
            b_dz_reg[0]   <= tdz_reg[TN-1];
            b_bz_reg[0]   <= t9_bz_reg;
            b_t_reg[0]    <= t9_t_reg;
            for (int i = 0; i < BW; i++) begin
                rn = {b_r_reg[i], b_nq_reg[i][BW-1]};
                ge = (rn >= {1'b0, b_d_reg[i]});
                rs = rn - {1'b0, b_d_reg[i]};
                b_r_reg[i+1]    <= ge ? rs[BW-1:0] : rn[BW-1:0];
                b_nq_reg[i+1]   <= {b_nq_reg[i][BW-2:0], ge};
                b_d_reg[i+1]    <= b_d_reg[i];
                b_post_reg[i+1] <= b_post_reg[i];
                b_dz_reg[i+1]   <= b_dz_reg[i];
                b_bz_reg[i+1]   <= b_bz_reg[i];
                b_t_reg[i+1]    <= b_t_reg[i];
            end
        end
    end

    // U stages: pressure correction
    localparam int UN = 5;
    logic uv_reg  [UN];
    logic uerr_reg[UN];
    logic [31:0] ut_reg [UN];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < UN; i++) uv_reg[i] <= 1'b0;
        end else if (adv) begin
            uv_reg[0] <= b_vld_reg[BW];
            for (int i = 1; i < UN; i++) uv_reg[i] <= uv_reg[i-1];
        end
    end

    logic [31:0] u1_p_reg, u2_p_reg, u3_p_reg, u4_p_reg;
    logic [31:0] u2_sq_reg, u2_m7_reg, u3_x1_reg, u3_x2_reg, u4_sum_reg, u5_pr_reg;
    logic [31:0] ps8, m7_neg;
    assign ps8    = bptc_pkg::asr(u1_p_reg, 8);
    assign m7_neg = 32'd0 - u2_m7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            u1_p_reg    <= b_post_reg[BW] ? {b_nq_reg[BW][30:0], 1'b0} : b_nq_reg[BW];
            uerr_reg[0] <= b_dz_reg[BW] | b_bz_reg[BW];
            ut_reg[0]   <= b_t_reg[BW];
            for (int i = 1; i < UN; i++) begin
                uerr_reg[i] <= uerr_reg[i-1];
                ut_reg[i]   <= ut_reg[i-1];
            end
            u2_sq_reg  <= ps8 * ps8;
            u2_m7_reg  <= bptc_pkg::K_C7357 * u1_p_reg;
            u2_p_reg   <= u1_p_reg;
            u3_x1_reg  <= u2_sq_reg * bptc_pkg::K_C3038;
            u3_x2_reg  <= bptc_pkg::asr(m7_neg, 16);
            u3_p_reg   <= u2_p_reg;
            u4_sum_reg <= bptc_pkg::asr(u3_x1_reg, 16) + u3_x2_reg + bptc_pkg::K_C3791;
            u4_p_reg   <= u3_p_reg;
            u5_pr_reg  <= u4_p_reg + bptc_pkg::asr(u4_sum_reg, 4);
        end
    end

    // output: saturation and status
    logic [15:0]        t_sat_next;
    logic [17:0]        p_sat_next;
    bptc_pkg::status_t  st_next;
    logic [31:0]        tf;
    always_comb begin
        tf = ut_reg[UN-1];
        st_next = bptc_pkg::STATUS_OK;
        if (!tf[31] && (tf > bptc_pkg::K_T_MAX)) begin
            t_sat_next = 16'h7FFF;
            st_next    = bptc_pkg::STATUS_SAT;
        end else if (tf[31] && (tf[30:15] != 16'hFFFF)) begin
            t_sat_next = 16'h8000;
            st_next    = bptc_pkg::STATUS_SAT;
        end else begin
            t_sat_next = tf[15:0];
        end
        if (u5_pr_reg[31]) begin
            p_sat_next = '0;
            st_next    = bptc_pkg::STATUS_SAT;
        end else if (u5_pr_reg > bptc_pkg::K_P_MAX) begin
            p_sat_next = bptc_pkg::K_P_MAX[17:0];
            st_next    = bptc_pkg::STATUS_SAT;
        end else begin
            p_sat_next = u5_pr_reg[17:0];
        end
        if (uerr_reg[UN-1]) begin
            t_sat_next = '0;
            p_sat_next = '0;
            st_next    = bptc_pkg::STATUS_DIV;
        end
    end

    logic [15:0]       out_t_reg;
    logic [17:0]       out_p_reg;
    bptc_pkg::status_t out_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= uv_reg[UN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_t_reg  <= t_sat_next;
            out_p_reg  <= p_sat_next;
            out_st_reg <= st_next;
        end
    end

    assign m_valid              = out_vld_reg;
    assign m_temperature_tenths = $signed(out_t_reg);
    assign m_pressure_pa        = out_p_reg;
    assign m_status             = out_st_reg;

endmodule

/* hdl/bptc_checker.sv */
// Port-level checker for the compensation core, with its bind
`include "baro_pressure_temp_compensation_core_assert.svh"

module bptc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_temperature_tenths,
    input logic [17:0] m_pressure_pa,
    input logic [1:0]  m_status
);

    `BPTC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_pressure_pa) && $stable(m_temperature_tenths), "result changed while stalled")
    `BPTC_ASSERT_NOW(a_div_zero, aclk, aresetn, m_valid && m_status == bptc_pkg::STATUS_DIV, m_temperature_tenths == 16'd0 && m_pressure_pa == 18'd0, "divide error with nonzero result")
    `BPTC_ASSERT_NOW(a_status, aclk, aresetn, m_valid, m_status == bptc_pkg::STATUS_OK || m_status == bptc_pkg::STATUS_DIV || m_status == bptc_pkg::STATUS_SAT, "bad status code")
    `BPTC_ASSERT_NOW(a_ready, aclk, aresetn, !m_valid || m_ready, s_ready, "input stalled with free output")

endmodule

bind baro_pressure_temp_compensation_core bptc_checker u_bptc_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_temperature_tenths (m_temperature_tenths),
    .m_pressure_pa        (m_pressure_pa),
    .m_status             (m_status)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the barometric compensation core
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [17:0]        pres;
        bptc_pkg::status_t  stat;
    } comp_result_t;

    class comp_scoreboard;
        comp_result_t pending[$];
        int errors;
        int checked;
        int n_div;
        int n_sat;
        logic [1:0]  oss;
        logic [47:0] ac123;
        logic [47:0] ac456;
        logic [31:0] b12;
        logic [31:0] mcmd;

        function void set_reg(logic [2:0] idx, logic [47:0] val);
            case (idx)
                bptc_pkg::REG_OSS:   oss = val[1:0];
                bptc_pkg::REG_AC123: ac123 = val;
                bptc_pkg::REG_AC456: ac456 = val;
                bptc_pkg::REG_B12:   b12 = val[31:0];
                bptc_pkg::REG_MCMD:  mcmd = val[31:0];
                default: ;
            endcase
        endfunction

        function automatic logic [31:0] sar(logic [31:0] v, int s);
            return $signed(v) >>> s;
        endfunction

        function automatic logic [31:0] ext(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function automatic comp_result_t compensate(logic [15:0] ut_in, logic [23:0] upw);
            logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, pr, den, t;
            longint sa, sb, ts, ps;
            comp_result_t r;
            ac1 = ext(ac123[47:32]); ac2 = ext(ac123[31:16]); ac3 = ext(ac123[15:0]);
            ac4 = {16'd0, ac456[47:32]}; ac5 = {16'd0, ac456[31:16]};
            ac6 = {16'd0, ac456[15:0]};
            b1 = ext(b12[31:16]); b2 = ext(b12[15:0]);
            mc = ext(mcmd[31:16]); md = ext(mcmd[15:0]);
            ut = {16'd0, ut_in};
            up = {8'd0, upw} >> (8 - oss);
            r = '0;
            x1 = sar((ut - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 0) begin
                r.stat = bptc_pkg::STATUS_DIV;
                return r;
            end
            sa = longint'($signed(mc << 11));
            sb = longint'($signed(den));
            x2 = 32'(sa / sb);
            b5 = x1 + x2;
            t = sar(b5 + 32'd8, 4);
            b6 = b5 - 32'd4000;
            x1 = sar(b2 * sar(b6 * b6, 12), 11);
            x2 = sar(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = sar(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
            x1 = sar(ac3 * b6, 13);
            x2 = sar(b1 * sar(b6 * b6, 12), 16);
            x3 = sar(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            if (b4 == 0) begin
                r.stat = bptc_pkg::STATUS_DIV;
                return r;
            end
            b7 = (up - b3) * (32'd50000 >> oss);
            if (!b7[31]) p = (b7 * 32'd2) / b4;
            else p = (b7 / b4) * 32'd2;
            x1 = sar(p, 8) * sar(p, 8);
            x1 = sar(x1 * 32'd3038, 16);
            x2 = sar(32'd0 - 32'd7357 * p, 16);
            pr = p + sar(x1 + x2 + 32'd3791, 4);
            r.stat = bptc_pkg::STATUS_OK;
            ts = longint'($signed(t));
            if (ts > 32767) begin ts = 32767; r.stat = bptc_pkg::STATUS_SAT; end
            if (ts < -32768) begin ts = -32768; r.stat = bptc_pkg::STATUS_SAT; end
            ps = longint'($signed(pr));
            if (ps > 262143) begin ps = 262143; r.stat = bptc_pkg::STATUS_SAT; end
            if (ps < 0) begin ps = 0; r.stat = bptc_pkg::STATUS_SAT; end
            r.temp = ts[15:0];
            r.pres = ps[17:0];
            return r;
        endfunction

        function void note_request(logic [15:0] ut_in, logic [23:0] upw);
            comp_result_t r;
            r = compensate(ut_in, upw);
            if (r.stat == bptc_pkg::STATUS_DIV) n_div++;
            if (r.stat == bptc_pkg::STATUS_SAT) n_sat++;
            pending.push_back(r);
        endfunction

        function void check_result(comp_result_t got);
            comp_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result temp=%0d pres=%0d status=%0d",
                         $time, got.temp, got.pres, got.stat);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.temp !== exp_r.temp) begin
                $display("%0t: temperature expected %0d actual %0d",
                         $time, exp_r.temp, got.temp);
                errors++;
            end
            if (got.pres !== exp_r.pres) begin
                $display("%0t: pressure expected %0d actual %0d",
                         $time, exp_r.pres, got.pres);
                errors++;
            end
            if (got.stat !== exp_r.stat) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_r.stat, got.stat);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 79;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_raw_temperature = '0;
    logic [23:0] s_raw_pressure_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_temperature_tenths;
    logic [17:0] m_pressure_pa;
    logic [1:0]  m_status;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_wdata = '0;

    comp_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;

    baro_pressure_temp_compensation_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check on accept, randomize ready for the next edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_temperature_tenths, m_pressure_pa, m_status});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_request(logic [15:0] ut, logic [23:0] upw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_temperature <= ut;
        s_raw_pressure_word <= upw;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(ut, upw);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // typical factory calibration set, slightly jittered
    task automatic load_typical(logic [1:0] oss);
        write_reg(bptc_pkg::REG_OSS, {46'd0, oss});
        write_reg(bptc_pkg::REG_AC123, {16'd408 + 16'($urandom_range(63)),
                                        -16'sd72, -16'sd14383});
        write_reg(bptc_pkg::REG_AC456,
                  {16'd32741, 16'd32757, 16'd23153 + 16'($urandom_range(255))});
        write_reg(bptc_pkg::REG_B12, {16'd0, 16'd6190, 16'd4});
        write_reg(bptc_pkg::REG_MCMD, {16'd0, -16'sd8711, 16'd2868});
    endtask

    task automatic load_random;
        write_reg(bptc_pkg::REG_OSS, 48'({$urandom, $urandom}));
        write_reg(bptc_pkg::REG_AC123, 48'({$urandom, $urandom}));
        write_reg(bptc_pkg::REG_AC456, 48'({$urandom, $urandom}));
        write_reg(bptc_pkg::REG_B12, 48'({$urandom, $urandom}));
        write_reg(bptc_pkg::REG_MCMD, 48'({$urandom, $urandom}));
    endtask

    task automatic run_phase(int n, bit typical);
        for (int i = 0; i < n; i++) begin
            if (typical && $urandom_range(9) != 0)
                send_request(16'd20000 + 16'($urandom_range(16000)),
                             24'h9F0000 + 24'($urandom_range(24'h3FFFFF)));
            else
                send_request(16'($urandom), 24'($urandom));
        end
        drain();
    endtask

    initial begin
        int phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero registers: AC4 = 0 forces a zero pressure divisor
        send_request(16'd0, 24'd0);
        send_request(16'hFFFF, 24'hFFFFFF);
        drain();

        load_typical(2'd0);
        send_request(16'd27898, 24'h5D23_00);
        send_request(16'd0, 24'd0);
        send_request(16'hFFFF, 24'hFFFFFF);
        send_request(16'h8000, 24'h800000);
        send_request(16'h7FFF, 24'h7FFFFF);
        drain();
        load_typical(2'd3);
        send_request(16'd27898, 24'h5D2300);
        send_request(16'hFFFF, 24'hFFFFFF);
        send_request(16'h0001, 24'h000001);
        drain();
        // zero temperature divisor: AC5 = 0 makes x1 = 0, MD = 0
        write_reg(bptc_pkg::REG_MCMD, {16'd0, 16'h8000, 16'd0});
        write_reg(bptc_pkg::REG_AC456, {16'hFFFF, 16'd0, 16'hFFFF});
        send_request(16'd1234, 24'h123456);
        drain();
        // extreme calibration words, unknown register index is a no-op
        write_reg(bptc_pkg::REG_AC123, {16'h7FFF, 16'h8000, 16'h7FFF});
        write_reg(bptc_pkg::REG_AC456, {16'hFFFF, 16'hFFFF, 16'h0000});
        write_reg(bptc_pkg::REG_B12, {16'd0, 16'h8000, 16'h7FFF});
        write_reg(bptc_pkg::REG_MCMD, {16'd0, 16'h7FFF, 16'h0001});
        write_reg(3'd5, '1);
        write_reg(3'd7, '1);
        send_request(16'hFFFF, 24'hFFFFFF);
        send_request(16'd0, 24'hFFFFFF);
        send_request(16'hAAAA, 24'h555555);
        send_request(16'h5555, 24'hAAAAAA);
        drain();

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (phase % 2 == 0) load_typical(2'(phase / 2));
            else load_random();
            run_phase(210, phase % 2 == 0);
        end

        $display("checked %0d results over 8 random phases and all oversampling settings",
                 sb.checked);
        $display("%0d divide-by-zero and %0d saturated results seen", sb.n_div, sb.n_sat);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
